// ===== design/spa_pkg.sv =====
// Shared constants, types and the priority table of the status priority aggregator.
package spa_pkg;

    localparam int NUM_SOURCES = 16;
    localparam int AGE_BITS    = 32;

    localparam int IDX_BITS   = $clog2(NUM_SOURCES);
    localparam int CNT_BITS   = $clog2(NUM_SOURCES + 1);
    localparam int CMP_BITS   = (CNT_BITS > 5) ? CNT_BITS : 5;
    localparam int WIDE_BITS  = ((IDX_BITS > 4) ? IDX_BITS : 4) + 1;

    localparam int STATUS_BITS  = 2;
    localparam int SOURCE_BITS  = 4;
    localparam int MODE_BITS    = 2;
    localparam int ACTIVE_BITS  = 5;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 5;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FAULT   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OFF     = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_WARNING = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PRIORITY_MODE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_SOURCES = 2'd1;

    localparam logic [MODE_BITS-1:0]   MODE_RESET   = 2'd0;
    localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 5'd16;

    typedef logic signed [2:0] rank_t;

    localparam rank_t UNRANKED = -3'sd1;

    localparam rank_t PRIO_TABLE [4][4] = '{
        '{ 3'sd0,  3'sd3,  3'sd1,  3'sd2},
        '{ 3'sd1,  3'sd3,  3'sd0,  3'sd2},
        '{-3'sd1,  3'sd3, -3'sd1,  3'sd2},
        '{ 3'sd0,  3'sd2,  3'sd3,  3'sd1}
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    function automatic rank_t rank_of(input logic [MODE_BITS-1:0] mode,
                                      input logic [STATUS_BITS-1:0] st);
        return PRIO_TABLE[mode][st];
    endfunction

endpackage

// ===== design/status_priority_aggregator.sv =====
// Top level of the status priority aggregator: status store, scan sequencer and result register.
//
// Each input word on the s_ channel writes the new status of one source and stamps it
// with the next value of a running update counter. The block then scans the active
// sources one per cycle through a single shared rank and age compare unit, keeping the
// status of highest rank in the selected priority mode; among equal statuses the older
// stamp wins. One result word per input word leaves on the m_ channel.
// An input word goes through an accept step, a scan step per active source and a step
// that loads the result register; s_ready is high only while the sequencer is idle.
// The result register holds a finished word while the receiver stalls, and the next
// input word is accepted and scanned meanwhile; it waits in its last step until the
// register is free. Configuration writes through cfg_we, cfg_index and cfg_wdata take
// effect at once and are meant to be issued only while the block is idle.
// Reset clears all statuses to OK, all stamps and the counter to zero, and sets the
// mode to zero and the active count to sixteen.
module status_priority_aggregator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [spa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [spa_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [3:0]                        s_source_index,
    input  logic [1:0]                        s_new_status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_agg_status,
    output logic [3:0]                        m_selected_source,
    output logic                              m_source_valid,
    output logic                              m_changed
);

    spa_pkg::state_t state_reg, state_next;

    logic [spa_pkg::MODE_BITS-1:0]   priority_mode_reg;
    logic [spa_pkg::ACTIVE_BITS-1:0] active_sources_reg;

    logic [spa_pkg::STATUS_BITS-1:0] status_mem [spa_pkg::NUM_SOURCES];
    logic [spa_pkg::AGE_BITS-1:0]    age_mem    [spa_pkg::NUM_SOURCES];
    logic [spa_pkg::AGE_BITS-1:0]    update_counter_reg;

    logic [spa_pkg::IDX_BITS-1:0]    scan_idx_reg;
    logic                            have_reg;
    logic                            valid_reg;
    logic [spa_pkg::STATUS_BITS-1:0] best_status_reg;
    logic [spa_pkg::IDX_BITS-1:0]    best_idx_reg;
    logic [spa_pkg::AGE_BITS-1:0]    best_age_reg;
    spa_pkg::rank_t                  best_rank_reg;

    logic [spa_pkg::STATUS_BITS-1:0] last_status_reg;
    logic [spa_pkg::SOURCE_BITS-1:0] last_source_reg;
    logic                            last_valid_reg;

    logic                            m_valid_reg;
    logic [spa_pkg::STATUS_BITS-1:0] m_status_reg;
    logic [spa_pkg::SOURCE_BITS-1:0] m_source_reg;
    logic                            m_source_valid_reg;
    logic                            m_changed_reg;

    logic                            accept;
    logic                            scan_step;
    logic                            load_out;
    logic                            scan_last;
    logic [spa_pkg::WIDE_BITS-1:0]   idx_wide;
    logic                            idx_ok;
    logic [spa_pkg::IDX_BITS-1:0]    wr_addr;
    logic [spa_pkg::CMP_BITS-1:0]    active_wide;
    logic [spa_pkg::CMP_BITS-1:0]    n_clamp;
    logic [spa_pkg::IDX_BITS-1:0]    n_last;
    logic [spa_pkg::STATUS_BITS-1:0] cur_status;
    logic [spa_pkg::AGE_BITS-1:0]    cur_age;
    spa_pkg::rank_t                  cur_rank;
    logic                            take;
    logic                            mixed;
    logic [spa_pkg::SOURCE_BITS-1:0] res_source;
    logic                            res_changed;
    logic                            out_free;

    assign accept   = s_valid && s_ready;
    assign idx_wide = spa_pkg::WIDE_BITS'(s_source_index);
    assign idx_ok   = idx_wide < spa_pkg::WIDE_BITS'(spa_pkg::NUM_SOURCES);
    assign wr_addr  = idx_wide[spa_pkg::IDX_BITS-1:0];

    always_comb begin
        active_wide = spa_pkg::CMP_BITS'(active_sources_reg);
        if (active_wide == '0) begin
            n_clamp = spa_pkg::CMP_BITS'(1);
        end else if (active_wide > spa_pkg::CMP_BITS'(spa_pkg::NUM_SOURCES)) begin
            n_clamp = spa_pkg::CMP_BITS'(spa_pkg::NUM_SOURCES);
        end else begin
            n_clamp = active_wide;
        end
    end

    assign n_last    = spa_pkg::IDX_BITS'(n_clamp - spa_pkg::CMP_BITS'(1));
    assign scan_last = scan_idx_reg == n_last;

    assign cur_status = status_mem[scan_idx_reg];
    assign cur_age    = age_mem[scan_idx_reg];
    assign cur_rank   = spa_pkg::rank_of(priority_mode_reg, cur_status);

    assign take = !have_reg || (cur_rank > best_rank_reg) ||
                  (cur_status == best_status_reg && valid_reg && cur_age < best_age_reg);
    assign mixed = (cur_rank == spa_pkg::UNRANKED) && (best_rank_reg == spa_pkg::UNRANKED) &&
                   (cur_status != best_status_reg);

    assign res_source  = valid_reg ? spa_pkg::SOURCE_BITS'(best_idx_reg) : '0;
    assign res_changed = (best_status_reg != last_status_reg) ||
                         (best_status_reg != spa_pkg::ST_OK &&
                          (valid_reg != last_valid_reg || res_source != last_source_reg));
    assign out_free    = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spa_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = spa_pkg::S_SCAN;
                end
            end
            spa_pkg::S_SCAN: begin
                if (scan_last) begin
                    state_next = spa_pkg::S_FINISH;
                end
            end
            spa_pkg::S_FINISH: begin
                if (out_free) begin
                    state_next = spa_pkg::S_IDLE;
                end
            end
            default: state_next = spa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        scan_step = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            spa_pkg::S_IDLE:   s_ready   = 1'b1;
            spa_pkg::S_SCAN:   scan_step = 1'b1;
            spa_pkg::S_FINISH: load_out  = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= spa_pkg::S_IDLE;
            priority_mode_reg  <= spa_pkg::MODE_RESET;
            active_sources_reg <= spa_pkg::ACTIVE_RESET;
            update_counter_reg <= '0;
            last_status_reg    <= spa_pkg::ST_OK;
            last_source_reg    <= '0;
            last_valid_reg     <= 1'b1;
            m_valid_reg        <= 1'b0;
            for (int i = 0; i < spa_pkg::NUM_SOURCES; i++) begin
                status_mem[i] <= spa_pkg::ST_OK;
                age_mem[i]    <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    spa_pkg::CFG_PRIORITY_MODE:
                        priority_mode_reg <= cfg_wdata[spa_pkg::MODE_BITS-1:0];
                    spa_pkg::CFG_ACTIVE_SOURCES:
                        active_sources_reg <= cfg_wdata[spa_pkg::ACTIVE_BITS-1:0];
                    default: ;
                endcase
            end
            if (accept && idx_ok) begin
                update_counter_reg <= update_counter_reg + spa_pkg::AGE_BITS'(1);
                status_mem[wr_addr] <= s_new_status;
                age_mem[wr_addr]    <= update_counter_reg + spa_pkg::AGE_BITS'(1);
            end
            if (load_out) begin
                m_valid_reg     <= 1'b1;
                last_status_reg <= best_status_reg;
                last_source_reg <= res_source;
                last_valid_reg  <= valid_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            scan_idx_reg <= '0;
            have_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end else if (scan_step) begin
            if (!scan_last) begin
                scan_idx_reg <= scan_idx_reg + spa_pkg::IDX_BITS'(1);
            end
            if (take) begin
                best_status_reg <= cur_status;
                best_idx_reg    <= scan_idx_reg;
                best_age_reg    <= cur_age;
                best_rank_reg   <= cur_rank;
                valid_reg       <= 1'b1;
                have_reg        <= 1'b1;
            end else if (mixed) begin
                best_status_reg <= spa_pkg::ST_WARNING;
                best_idx_reg    <= '0;
                best_rank_reg   <= spa_pkg::rank_of(priority_mode_reg, spa_pkg::ST_WARNING);
                valid_reg       <= 1'b0;
            end
        end
        if (load_out) begin
            m_status_reg       <= best_status_reg;
            m_source_reg       <= res_source;
            m_source_valid_reg <= valid_reg;
            m_changed_reg      <= res_changed;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_agg_status      = m_status_reg;
    assign m_selected_source = m_source_reg;
    assign m_source_valid    = m_source_valid_reg;
    assign m_changed         = m_changed_reg;

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == spa_pkg::S_SCAN |-> scan_idx_reg <= n_last)
        else $error("Scan index ran past the active sources.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> !(m_valid_reg && !m_ready))
        else $error("Result register loaded while a word is still held.");

    a_sourceless_is_warning: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_source_valid |-> m_agg_status == spa_pkg::ST_WARNING &&
                                       m_selected_source == '0)
        else $error("A result without a source must be a warning at index zero.");

    a_counter_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && idx_ok |=> update_counter_reg == $past(update_counter_reg) +
                                                   spa_pkg::AGE_BITS'(1))
        else $error("Update counter did not advance on a status write.");

endmodule

// ===== tb/status_priority_aggregator_tb.sv =====
// Self-checking testbench for the status priority aggregator, driven from a table and then at random.
module status_priority_aggregator_tb;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int SCAN_LATENCY    = spa_pkg::NUM_SOURCES + 4;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_PHASES   = 13;
    localparam int WORDS_PER_PHASE = 50;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_PHASE      = 9;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [spa_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [spa_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

    localparam int NO_RANK = -1;

    localparam int STATUS_RANK [4][4] = '{
        '{ 0, 3,  1, 2},
        '{ 1, 3,  0, 2},
        '{-1, 3, -1, 2},
        '{ 0, 2,  3, 1}
    };

    typedef struct packed {
        logic [spa_pkg::STATUS_BITS-1:0] agg_status;
        logic [spa_pkg::SOURCE_BITS-1:0] selected_source;
        logic                            source_valid;
        logic                            changed;
    } agg_word_t;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    typedef enum int {
        MIX_ANY,
        MIX_OK_OFF,
        MIX_MOSTLY_OK_OFF
    } status_mix_t;

    typedef struct packed {
        row_kind_t                         kind;
        logic [3:0]                        sel;
        logic [spa_pkg::STATUS_BITS-1:0]   status;
        logic [spa_pkg::CFG_DATA_BITS-1:0] data;
        logic                              typed;
        agg_word_t                         want;
    } dir_row_t;

    localparam agg_word_t NO_WORD = '0;
    localparam int DIR_ROWS = 36;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_WORD, 4'd5,  spa_pkg::ST_FAULT,   5'd0, 1'b1,
          '{spa_pkg::ST_FAULT, 4'd5, 1'b1, 1'b1}},
        '{ROW_WORD, 4'd3,  spa_pkg::ST_WARNING, 5'd0, 1'b1,
          '{spa_pkg::ST_FAULT, 4'd5, 1'b1, 1'b0}},
        '{ROW_WORD, 4'd5,  spa_pkg::ST_OK,      5'd0, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd15, spa_pkg::ST_FAULT,   5'd0, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd0,  spa_pkg::ST_WARNING, 5'd0, 1'b0, NO_WORD},
        '{ROW_REG,  4'(spa_pkg::CFG_PRIORITY_MODE),  spa_pkg::ST_OK, 5'd3, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd7,  spa_pkg::ST_OFF,     5'd0, 1'b1,
          '{spa_pkg::ST_OFF, 4'd7, 1'b1, 1'b1}},
        '{ROW_WORD, 4'd15, spa_pkg::ST_OK,      5'd0, 1'b0, NO_WORD},
        '{ROW_REG,  4'(spa_pkg::CFG_PRIORITY_MODE),  spa_pkg::ST_OK, 5'd1, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd7,  spa_pkg::ST_OK,      5'd0, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd15, spa_pkg::ST_OFF,     5'd0, 1'b0, NO_WORD},
        '{ROW_REG,  4'(spa_pkg::CFG_PRIORITY_MODE),  spa_pkg::ST_OK, 5'd2, 1'b0, NO_WORD},
        '{ROW_REG,  4'(spa_pkg::CFG_ACTIVE_SOURCES), spa_pkg::ST_OK, 5'd4, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd3,  spa_pkg::ST_OK,      5'd0, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd0,  spa_pkg::ST_OFF,     5'd0, 1'b1,
          '{spa_pkg::ST_WARNING, 4'd0, 1'b0, 1'b1}},
        '{ROW_WORD, 4'd10, spa_pkg::ST_FAULT,   5'd0, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd1,  spa_pkg::ST_OFF,     5'd0, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd2,  spa_pkg::ST_FAULT,   5'd0, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd2,  spa_pkg::ST_OK,      5'd0, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd0,  spa_pkg::ST_OK,      5'd0, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd1,  spa_pkg::ST_OK,      5'd0, 1'b0, NO_WORD},
        '{ROW_REG,  4'(spa_pkg::CFG_ACTIVE_SOURCES), spa_pkg::ST_OK, 5'd0, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd1,  spa_pkg::ST_FAULT,   5'd0, 1'b0, NO_WORD},
        '{ROW_REG,  4'(spa_pkg::CFG_ACTIVE_SOURCES), spa_pkg::ST_OK, 5'd31, 1'b0, NO_WORD},
        '{ROW_REG,  4'(spa_pkg::CFG_PRIORITY_MODE),  spa_pkg::ST_OK, 5'b11100, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd10, spa_pkg::ST_OK,      5'd0, 1'b0, NO_WORD},
        '{ROW_REG,  4'(CFG_SPARE_LO),                spa_pkg::ST_OK, 5'd7, 1'b0, NO_WORD},
        '{ROW_REG,  4'(CFG_SPARE_HI),                spa_pkg::ST_OK, 5'd31, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd15, spa_pkg::ST_WARNING, 5'd0, 1'b0, NO_WORD},
        '{ROW_REG,  4'(spa_pkg::CFG_PRIORITY_MODE),  spa_pkg::ST_OK, 5'b10110, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd4,  spa_pkg::ST_OFF,     5'd0, 1'b0, NO_WORD},
        '{ROW_REG,  4'(spa_pkg::CFG_ACTIVE_SOURCES), spa_pkg::ST_OK, 5'd1, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd0,  spa_pkg::ST_FAULT,   5'd0, 1'b0, NO_WORD},
        '{ROW_REG,  4'(spa_pkg::CFG_ACTIVE_SOURCES), spa_pkg::ST_OK, 5'd16, 1'b0, NO_WORD},
        '{ROW_REG,  4'(spa_pkg::CFG_PRIORITY_MODE),  spa_pkg::ST_OK, 5'd0, 1'b0, NO_WORD},
        '{ROW_WORD, 4'd9,  spa_pkg::ST_OK,      5'd0, 1'b0, NO_WORD}
    };

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [spa_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [spa_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [3:0]                        s_source_index = '0;
    logic [1:0]                        s_new_status = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [1:0]                        m_agg_status;
    logic [3:0]                        m_selected_source;
    logic                              m_source_valid;
    logic                              m_changed;

    logic [spa_pkg::STATUS_BITS-1:0] src_status [spa_pkg::NUM_SOURCES] =
        '{default: spa_pkg::ST_OK};
    logic [spa_pkg::AGE_BITS-1:0]    src_age [spa_pkg::NUM_SOURCES] = '{default: '0};
    logic [spa_pkg::AGE_BITS-1:0]    stamp_count = '0;
    logic [spa_pkg::STATUS_BITS-1:0] last_status = spa_pkg::ST_OK;
    logic [spa_pkg::SOURCE_BITS-1:0] last_source = '0;
    logic                            last_valid = 1'b1;
    logic [spa_pkg::MODE_BITS-1:0]   mode_cfg = spa_pkg::MODE_RESET;
    logic [spa_pkg::ACTIVE_BITS-1:0] active_cfg = spa_pkg::ACTIVE_RESET;

    agg_word_t expected_words [$];
    int        fail_count = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 25;
    int        recv_idle_pct = 55;
    logic      hold_on = 1'b0;
    event      hold_go;

    status_priority_aggregator dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_source_index    (s_source_index),
        .s_new_status      (s_new_status),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_agg_status      (m_agg_status),
        .m_selected_source (m_selected_source),
        .m_source_valid    (m_source_valid),
        .m_changed         (m_changed)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic agg_word_t predict_aggregate(
        input logic [3:0]                      idx,
        input logic [spa_pkg::STATUS_BITS-1:0] nst);
        int                              n;
        int                              i;
        int                              p;
        int                              best_rank;
        int                              org;
        logic [spa_pkg::STATUS_BITS-1:0] st;
        logic                            have;
        logic                            has_src;
        agg_word_t                       w;
        stamp_count = stamp_count + 1'b1;
        src_status[idx] = nst;
        src_age[idx] = stamp_count;
        n = active_cfg;
        if (n < 1) n = 1;
        if (n > spa_pkg::NUM_SOURCES) n = spa_pkg::NUM_SOURCES;
        have = 1'b0;
        has_src = 1'b0;
        st = spa_pkg::ST_OK;
        org = 0;
        best_rank = 0;
        for (i = 0; i < n; i++) begin
            p = STATUS_RANK[mode_cfg][src_status[i]];
            if (!have || p > best_rank ||
                (src_status[i] == st && has_src && src_age[i] < src_age[org])) begin
                st = src_status[i];
                org = i;
                has_src = 1'b1;
                best_rank = p;
                have = 1'b1;
            end else if (p == NO_RANK) begin
                // An unranked status unlike the one held means OK and OFF are mixed.
                if (best_rank == NO_RANK && src_status[i] != st) begin
                    st = spa_pkg::ST_WARNING;
                    has_src = 1'b0;
                    org = 0;
                    best_rank = STATUS_RANK[mode_cfg][spa_pkg::ST_WARNING];
                end
            end
        end
        if (!has_src) org = 0;
        w.agg_status = st;
        w.selected_source = org[spa_pkg::SOURCE_BITS-1:0];
        w.source_valid = has_src;
        w.changed = (st != last_status) ||
                    (st != spa_pkg::ST_OK && (has_src != last_valid ||
                                     org[spa_pkg::SOURCE_BITS-1:0] != last_source));
        last_status = st;
        last_source = org[spa_pkg::SOURCE_BITS-1:0];
        last_valid = has_src;
        return w;
    endfunction

    task automatic send_word(input logic [3:0] idx,
                             input logic [spa_pkg::STATUS_BITS-1:0] st,
                             input logic typed, input agg_word_t want);
        agg_word_t predicted;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_source_index <= idx;
        s_new_status <= st;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_aggregate(idx, st);
        expected_words.push_back(typed ? want : predicted);
    endtask

    task automatic drain_block();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SCAN_LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [spa_pkg::CFG_IDX_BITS-1:0] index,
                             input logic [spa_pkg::CFG_DATA_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (index == spa_pkg::CFG_PRIORITY_MODE) mode_cfg = value[spa_pkg::MODE_BITS-1:0];
        else if (index == spa_pkg::CFG_ACTIVE_SOURCES) active_cfg = value;
    endtask

    always @(posedge aclk) begin
        agg_word_t got;
        agg_word_t want;
        got = '{m_agg_status, m_selected_source, m_source_valid, m_changed};
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                if (fail_count < REPORT_LIMIT)
                    $display("unexpected word: status %0d source %0d valid %0b changed %0b",
                             got.agg_status, got.selected_source, got.source_valid,
                             got.changed);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("mismatch: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                                 want.agg_status, want.selected_source, want.source_valid,
                                 want.changed, got.agg_status, got.selected_source,
                                 got.source_valid, got.changed);
                    fail_count++;
                end
            end
        end
        if (hold_on) m_ready <= 1'b0;
        else if (recv_idle_pct == 0) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        @(hold_go);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int                              r;
        int                              ph;
        int                              k;
        int                              act;
        int                              eff;
        status_mix_t                     mix;
        logic [3:0]                      idx;
        logic [spa_pkg::STATUS_BITS-1:0] st;
        logic                            busy;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        busy = 1'b0;
        for (r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_REG) begin
                if (busy) drain_block();
                busy = 1'b0;
                write_reg(DIRECTED[r].sel[spa_pkg::CFG_IDX_BITS-1:0], DIRECTED[r].data);
            end else begin
                send_word(DIRECTED[r].sel, DIRECTED[r].status, DIRECTED[r].typed,
                          DIRECTED[r].want);
                busy = 1'b1;
            end
        end
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_block();
            if (ph == 4) begin
                send_idle_pct = 55;
                recv_idle_pct <= 25;
            end
            if (ph == 8) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            unique case (ph % 5)
                0: begin
                    act = spa_pkg::NUM_SOURCES;
                end
                1: begin
                    act = 1;
                end
                2: begin
                    act = $urandom_range(31);
                end
                3: begin
                    act = $urandom_range(spa_pkg::NUM_SOURCES - 1, 2);
                end
                default: begin
                    act = $urandom_range(1) ? 31 : 0;
                end
            endcase
            write_reg(spa_pkg::CFG_PRIORITY_MODE, {3'($urandom_range(7)), 2'(ph % 4)});
            write_reg(spa_pkg::CFG_ACTIVE_SOURCES, 5'(act));
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 5'($urandom));
            eff = (act < 1) ? 1 : ((act > spa_pkg::NUM_SOURCES) ? spa_pkg::NUM_SOURCES : act);
            if (ph % 4 == 2) mix = status_mix_t'(1 + $urandom_range(1));
            else mix = status_mix_t'($urandom_range(2));
            if (ph == HOLD_PHASE) -> hold_go;
            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                if ($urandom_range(99) < 80) idx = 4'($urandom_range(eff - 1));
                else idx = 4'($urandom_range(15));
                unique case (mix)
                    MIX_OK_OFF: begin
                        st = $urandom_range(1) ? spa_pkg::ST_OFF : spa_pkg::ST_OK;
                    end
                    MIX_MOSTLY_OK_OFF: begin
                        if ($urandom_range(99) < 10)
                            st = $urandom_range(1) ? spa_pkg::ST_FAULT : spa_pkg::ST_WARNING;
                        else
                            st = $urandom_range(1) ? spa_pkg::ST_OFF : spa_pkg::ST_OK;
                    end
                    default: begin
                        st = 2'($urandom_range(3));
                    end
                endcase
                send_word(idx, st, 1'b0, NO_WORD);
            end
        end
        drain_block();
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
